### hdl/text_console_writer_macros.svh
// Assertion macros for the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer check failed");
// Antecedent implies consequent in the next cycle.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer check failed");
`else
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tcw_pkg.sv
// Package with types, geometry and character codes of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = ROWS * COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int COLX_W = COL_W + 1;
  localparam int ROWX_W = ROW_W + 1;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CODE_W = 8;
  localparam int FUNC_W = 2;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_DEL   = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_READ  = 2'd2
  } tcw_func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_SCROLL_TAIL,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic capture;
    logic put_step;
    logic home;
    logic rd_cell;
    logic copy_step;
    logic fill;
    logic fill_init;
    logic cnt_zero;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    tcw_func_t func;
    logic      scroll;
    logic      copy_last;
    logic      fill_last;
  } tcw_sts_t;

endpackage

`default_nettype wire

### hdl/tcw_datapath.sv
// Datapath: cell buffer, cursor, attribute, sweep counter and result registers.
`default_nettype none

module tcw_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tcw_pkg::tcw_cmd_t            cmd,
  output tcw_pkg::tcw_sts_t                 sts,
  input  wire logic [tcw_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [tcw_pkg::CODE_W-1:0]   in_char_code,
  input  wire logic [tcw_pkg::ADDR_W-1:0]   in_cell_index,
  input  wire logic                         cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_text_attribute,
  output logic      [tcw_pkg::CELL_W-1:0]   out_cell_value,
  output logic      [tcw_pkg::COL_W-1:0]    out_cursor_col,
  output logic      [tcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic      [tcw_pkg::ADDR_W-1:0]   out_cursor_location
);

  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  logic [FUNC_W-1:0] func_r;
  logic [CODE_W-1:0] code_r;
  logic [ADDR_W-1:0] idx_r;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              copy_pend_r;
  logic [ADDR_W-1:0] copy_addr_r;
  logic [CELL_W-1:0] rd_data_r;
  logic [CELL_W-1:0] cell_out_r;
  logic [COL_W-1:0]  col_out_r;
  logic [ROW_W-1:0]  row_out_r;
  logic [ADDR_W-1:0] loc_out_r;

  logic [COLX_W-1:0] col_t;
  logic [ROWX_W-1:0] row_t;
  logic              printable;
  logic              scroll;
  logic [COL_W-1:0]  col_put;
  logic [ROW_W-1:0]  row_put;
  logic [ADDR_W-1:0] cur_loc;
  logic              idx_ok;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign cur_loc = ADDR_W'(ADDR_W'(cur_row_r) * ADDR_W'(COLUMNS)) + ADDR_W'(cur_col_r);
  assign idx_ok  = idx_r < ADDR_W'(CELLS);

  // cursor motion for one put request
  always_comb begin
    col_t     = {1'b0, cur_col_r};
    row_t     = {1'b0, cur_row_r};
    printable = 1'b0;
    case (code_r)
      CH_BS: begin
        if (cur_col_r != '0) begin
          col_t = col_t - COLX_W'(1);
        end
      end
      CH_TAB: begin
        col_t = COLX_W'((int'(cur_col_r) / TAB_WIDTH + 1) * TAB_WIDTH);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = row_t + ROWX_W'(1);
      end
      default: begin
        if (code_r inside {[CH_SPACE:CH_DEL]}) begin
          printable = 1'b1;
          col_t     = col_t + COLX_W'(1);
        end
      end
    endcase
    if (col_t >= COLX_W'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + ROWX_W'(1);
    end
    scroll  = row_t >= ROWX_W'(ROWS);
    col_put = col_t[COL_W-1:0];
    row_put = scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd.home) begin
      cur_col_nxt = '0;
      cur_row_nxt = '0;
    end else if (cmd.put_step) begin
      cur_col_nxt = col_put;
      cur_row_nxt = row_put;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_zero) begin
      cnt_nxt = '0;
    end else if (cmd.copy_step || cmd.fill) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end
  end

  // one write port: pending copy, then fill, then printable character
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = {attr_r, CH_SPACE};
    if (copy_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = copy_addr_r;
      wr_data = rd_data_r;
    end else if (cmd.fill) begin
      wr_en   = 1'b1;
      wr_data = cmd.fill_init ? BLANK_RESET : {attr_r, CH_SPACE};
    end else if (cmd.put_step && printable) begin
      wr_en   = 1'b1;
      wr_addr = cur_loc;
      wr_data = {attr_r, code_r};
    end
  end

  assign rd_en   = cmd.copy_step || (cmd.rd_cell && idx_ok);
  assign rd_addr = cmd.copy_step ? cnt_r + ADDR_W'(COLUMNS) : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      attr_r      <= ATTR_RESET;
      cnt_r       <= '0;
      copy_pend_r <= 1'b0;
    end else begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cnt_r       <= cnt_nxt;
      copy_pend_r <= cmd.copy_step;
      if (cfg_we) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      code_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
    if (cmd.copy_step) begin
      copy_addr_r <= cnt_r;
    end
    if (cmd.load_out) begin
      cell_out_r <= (tcw_func_t'(func_r) == FN_READ && idx_ok) ? rd_data_r : '0;
      col_out_r  <= cur_col_r;
      row_out_r  <= cur_row_r;
      loc_out_r  <= cur_loc;
    end
  end

  assign sts.func      = tcw_func_t'(func_r);
  assign sts.scroll    = scroll;
  assign sts.copy_last = cnt_r == ADDR_W'(CELLS - COLUMNS - 1);
  assign sts.fill_last = cnt_r == ADDR_W'(CELLS - 1);

  assign out_cell_value      = cell_out_r;
  assign out_cursor_col      = col_out_r;
  assign out_cursor_row      = row_out_r;
  assign out_cursor_location = loc_out_r;

endmodule

`default_nettype wire

### hdl/tcw_ctrl.sv
// Controller state machine of the text console writer.
`default_nettype none
`include "text_console_writer_macros.svh"

module tcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire tcw_pkg::tcw_sts_t  sts,
  output tcw_pkg::tcw_cmd_t       cmd
);

  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.func)
          FN_PUT:   state_nxt = sts.scroll ? ST_SCROLL : ST_DONE;
          FN_CLEAR: state_nxt = ST_FILL;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_SCROLL: begin
        if (sts.copy_last) begin
          state_nxt = ST_SCROLL_TAIL;
        end
      end
      ST_SCROLL_TAIL: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (sts.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_INIT: begin
        cmd.fill      = 1'b1;
        cmd.fill_init = 1'b1;
      end
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        case (sts.func)
          FN_PUT: begin
            cmd.put_step = 1'b1;
            cmd.cnt_zero = sts.scroll;
          end
          FN_CLEAR: begin
            cmd.home     = 1'b1;
            cmd.cnt_zero = 1'b1;
          end
          FN_READ: begin
            cmd.rd_cell = 1'b1;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.copy_step = 1'b1;
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  `TCW_ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.load_out, !out_valid_r || !out_stall)
  `TCW_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && !in_stall, state_r == ST_DECODE)
  `TCW_ASSERT_NEXT(a_copy_drains, clk, rst_n, state_r == ST_SCROLL && sts.copy_last, state_r == ST_SCROLL_TAIL)
  `TCW_ASSERT_IMPL(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE))

endmodule

`default_nettype wire

### hdl/text_console_writer.sv
// Top level of the text console writer: controller plus datapath.
// Text console over a 25-row by 80-column buffer of 16-bit cells (attribute in the high
// byte, character in the low byte), held in one single-port-write, single-port-read
// memory. After reset the block clears the buffer to 0x0F20, one cell a cycle, and keeps
// in_stall high until all 2000 cells are written; configuration writes are taken
// throughout. A put of a control or printable character, a read or an unused request
// passes the decode and done states; a read uses the registered memory read. A put
// that scrolls also makes 1920 cell copies through the one read and one write port,
// passes a drain state and writes 80 blank cells; a clear writes all 2000 cells. The
// result register lets the next request be taken while a result waits.
`default_nettype none

module text_console_writer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [tcw_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [tcw_pkg::CODE_W-1:0]   in_char_code,
  input  wire logic [tcw_pkg::ADDR_W-1:0]   in_cell_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [tcw_pkg::CELL_W-1:0]   out_cell_value,
  output logic      [tcw_pkg::COL_W-1:0]    out_cursor_col,
  output logic      [tcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic      [tcw_pkg::ADDR_W-1:0]   out_cursor_location,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_text_attribute
);

  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute),
    .out_cell_value      (out_cell_value),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_location (out_cursor_location)
  );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the text console writer: random and directed requests checked against a shadow console.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT    = 20_000_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 200;
  localparam int CALM_PHASE     = 3;
  localparam int SETTLE_CYCLES  = 20;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [CODE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CODE_W-1:0] CH_US     = 8'h1F;
  localparam logic [CODE_W-1:0] CH_HIGH   = 8'h80;
  localparam logic [CODE_W-1:0] CH_A      = 8'h41;
  localparam logic [CODE_W-1:0] CH_W      = 8'h57;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_location;
  } cursor_report_t;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func            = '0;
  logic [CODE_W-1:0] in_char_code       = '0;
  logic [ADDR_W-1:0] in_cell_index      = '0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [CELL_W-1:0] out_cell_value;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [ADDR_W-1:0] out_cursor_location;
  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_text_attribute = '0;

  logic [CELL_W-1:0] screen_cells [CELLS];
  int                shadow_col;
  int                shadow_row;
  logic [ATTR_W-1:0] shadow_attr;
  cursor_report_t    awaited_reports [$];
  int                mismatches  = 0;
  int                cycle_count = 0;
  int                idle_pct    = 9;

  text_console_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_value      (out_cell_value),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_location (out_cursor_location),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void blank_cells(int first, int last);
    for (int i = first; i < last; i++) begin
      screen_cells[i] = {shadow_attr, CH_SPACE};
    end
  endfunction

  function automatic cursor_report_t console_step(logic [FUNC_W-1:0] func,
                                                  logic [CODE_W-1:0] code,
                                                  logic [ADDR_W-1:0] index);
    cursor_report_t rep;
    rep = '0;
    if (func == FN_PUT) begin
      case (code)
        CH_BS: begin
          if (shadow_col != 0) shadow_col--;
        end
        CH_TAB: shadow_col = (shadow_col + TAB_WIDTH) / TAB_WIDTH * TAB_WIDTH;
        CH_CR: shadow_col = 0;
        CH_LF: begin
          shadow_col = 0;
          shadow_row++;
        end
        default: begin
          if (code >= CH_SPACE && code <= CH_DEL) begin
            screen_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
            shadow_col++;
          end
        end
      endcase
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
      if (shadow_row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
          screen_cells[i] = screen_cells[i + COLUMNS];
        end
        blank_cells(CELLS - COLUMNS, CELLS);
        shadow_row = ROWS - 1;
      end
    end else if (func == FN_CLEAR) begin
      blank_cells(0, CELLS);
      shadow_col = 0;
      shadow_row = 0;
    end else if (func == FN_READ && index < CELLS) begin
      rep.cell_value = screen_cells[index];
    end
    rep.cursor_col      = COL_W'(shadow_col);
    rep.cursor_row      = ROW_W'(shadow_row);
    rep.cursor_location = ADDR_W'(shadow_row * COLUMNS + shadow_col);
    return rep;
  endfunction

  always @(posedge clk) begin
    cursor_report_t seen;
    cursor_report_t want;
    if (!rst_n) begin
      shadow_attr = ATTR_RESET;
      blank_cells(0, CELLS);
      shadow_col = 0;
      shadow_row = 0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) shadow_attr = cfg_text_attribute;
      if (in_valid && !in_stall) begin
        awaited_reports.push_back(console_step(in_func, in_char_code, in_cell_index));
      end
      if (out_valid && !out_stall) begin
        seen = '{out_cell_value, out_cursor_col, out_cursor_row, out_cursor_location};
        if (awaited_reports.size() == 0) begin
          $error("result with no request pending: cell_value %h cursor %0d,%0d",
                 seen.cell_value, seen.cursor_row, seen.cursor_col);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (seen.cell_value !== want.cell_value) begin
            $error("cell_value expected %h actual %h", want.cell_value, seen.cell_value);
            mismatches++;
          end
          if (seen.cursor_col !== want.cursor_col) begin
            $error("cursor_col expected %0d actual %0d", want.cursor_col, seen.cursor_col);
            mismatches++;
          end
          if (seen.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d actual %0d", want.cursor_row, seen.cursor_row);
            mismatches++;
          end
          if (seen.cursor_location !== want.cursor_location) begin
            $error("cursor_location expected %0d actual %0d",
                   want.cursor_location, seen.cursor_location);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall   <= ($urandom_range(0, 99) < idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(logic [FUNC_W-1:0] func, logic [CODE_W-1:0] code,
                              logic [ADDR_W-1:0] index);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_char_code  <= code;
    in_cell_index <= index;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_text_attribute(logic [ATTR_W-1:0] attr);
    drain_reports();
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= attr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_power_on_screen();
    send_request(FN_READ, CH_NUL, 11'd0);
    send_request(FN_READ, 8'hFF, ADDR_W'(CELLS - 1));
    send_request(FN_READ, CH_NUL, ADDR_W'(CELLS));
    send_request(FN_UNUSED, 8'hFF, 11'h7FF);
  endtask

  task automatic test_control_codes();
    send_request(FN_PUT, CH_BS, 11'd0);
    send_request(FN_PUT, CH_SPACE, 11'd0);
    send_request(FN_PUT, CH_DEL, 11'd0);
    send_request(FN_PUT, CH_A, 11'd0);
    send_request(FN_PUT, CH_BS, 11'd0);
    send_request(FN_PUT, CH_TAB, 11'd0);
    send_request(FN_PUT, CH_CR, 11'd0);
    send_request(FN_PUT, CH_US, 11'd0);
    send_request(FN_PUT, CH_HIGH, 11'd0);
    send_request(FN_PUT, CH_LF, 11'd0);
    send_request(FN_READ, CH_NUL, 11'd1);
  endtask

  task automatic test_line_wrap();
    send_request(FN_PUT, CH_W, 11'd0);
    repeat (COLUMNS / TAB_WIDTH) send_request(FN_PUT, CH_TAB, 11'd0);
    send_request(FN_READ, CH_NUL, ADDR_W'(COLUMNS));
  endtask

  task automatic test_clear_screen();
    send_request(FN_CLEAR, CH_NUL, 11'd0);
    send_request(FN_READ, CH_NUL, ADDR_W'(COLUMNS));
  endtask

  task automatic send_random_request();
    int                pick;
    int                kind;
    int                lf_pct;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] index;
    pick  = $urandom_range(0, 999);
    code  = CODE_W'($urandom_range(0, 255));
    index = ADDR_W'($urandom_range(0, 2047));
    kind  = $urandom_range(0, 99);
    if (pick < 5) begin
      send_request(FN_CLEAR, code, index);
    end else if (pick < 25) begin
      send_request(FN_UNUSED, code, index);
    end else if (pick < 250) begin
      if (kind < 50) begin
        index = ADDR_W'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      end else if (kind < 85) begin
        index = ADDR_W'($urandom_range(0, CELLS - 1));
      end
      send_request(FN_READ, code, index);
    end else begin
      // hold the bottom row mostly steady: every scroll walks the whole buffer
      lf_pct = (shadow_row < ROWS - 1) ? 18 : 3;
      if (kind < lf_pct) begin
        code = CH_LF;
      end else if (kind < lf_pct + 5) begin
        code = CH_CR;
      end else if (kind < lf_pct + 11) begin
        code = CH_TAB;
      end else if (kind < lf_pct + 17) begin
        code = CH_BS;
      end else if (kind >= lf_pct + 25) begin
        code = CODE_W'($urandom_range(CH_SPACE, CH_DEL));
      end
      send_request(FN_PUT, code, index);
    end
  endtask

  task automatic test_random_text(int phase);
    case (phase)
      0: set_text_attribute(8'h00);
      1: set_text_attribute(8'hFF);
      default: set_text_attribute(ATTR_W'($urandom_range(0, 255)));
    endcase
    idle_pct = (phase == CALM_PHASE) ? 0 : 9;
    repeat (PHASE_REQUESTS) send_random_request();
    idle_pct = 9;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on_screen();
    test_control_codes();
    set_text_attribute(8'hFF);
    test_line_wrap();
    test_clear_screen();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      test_random_text(phase);
    end
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
